// ===== src/kmae_pkg.sv =====
package kmae_pkg;

	localparam int unsigned NUM_ROWS  = 7;
	localparam int unsigned ROW_BITS  = 8;
	localparam int unsigned CODE_BITS = 7;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [2:0]           row_idx_t;
	typedef logic [2:0]           col_t;

	// Rows of the key matrix by role.
	localparam row_idx_t ROW_DIGITS    = 3'd0;
	localparam row_idx_t ROW_SIGNS     = 3'd1;
	localparam row_idx_t ROW_LETTER_LO = 3'd2;
	localparam row_idx_t ROW_LETTER_HI = 3'd4;
	localparam row_idx_t ROW_LAST_ALPHA = 3'd5;
	localparam row_idx_t ROW_FIXED     = 3'd6;

	// Item kinds carried by func.
	localparam logic FUNC_SCAN = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic  hit;
		code_t code;
	} lane_res_t;

	function automatic code_t fixed_code(input col_t c);
		code_t r;
		unique case (c)
			3'd0: r = 7'h11;
			3'd1: r = 7'h12;
			3'd2: r = 7'h13;
			3'd3: r = 7'h14;
			3'd4: r = 7'h20;
			3'd5: r = 7'h0D;
			3'd6: r = 7'h09;
			3'd7: r = 7'h0A;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/kmae_lane.sv =====
module kmae_lane
	import kmae_pkg::*;
(
	input  row_idx_t             row_idx,
	input  logic [ROW_BITS-1:0]  row,
	input  logic                 shift_down,
	input  logic                 ctrl_down,
	output lane_res_t            res
);

	col_t  c;
	code_t c7;
	logic  [1:0] letter_grp;
	code_t grp_ofs;

	always_comb begin
		c = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (row[i]) begin
				c = col_t'(i);
			end
		end
	end

	assign c7         = {4'b0, c};
	assign letter_grp = 2'(row_idx - ROW_LETTER_LO);
	assign grp_ofs    = {2'b0, letter_grp, 3'b0};

	always_comb begin
		res.hit  = |row;
		res.code = '0;
		priority if (row_idx == ROW_DIGITS) begin
			res.code = (shift_down ? 7'h20 : 7'h30) + c7;
		end else if (row_idx == ROW_SIGNS) begin
			res.code = (((c < 3'd4) != shift_down) ? 7'h38 : 7'h28) + c7;
		end else if (row_idx <= ROW_LETTER_HI) begin
			res.code = (ctrl_down ? 7'h00 : (shift_down ? 7'h60 : 7'h40)) + c7 + grp_ofs;
		end else if (row_idx == ROW_LAST_ALPHA) begin
			if (!ctrl_down) begin
				res.code = (((c != 3'd7) == shift_down) ? 7'h78 : 7'h58) + c7;
			end else if (!shift_down) begin
				res.code = 7'h18 + c7;
			end else begin
				// Shift with ctrl on this row leaves the earlier code standing.
				res.hit = 1'b0;
			end
		end else begin
			res.code = fixed_code(c);
		end
	end

endmodule

// ===== src/kmae_merge.sv =====
module kmae_merge
	import kmae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic                 func_s1,
	input  lane_res_t            lane_s1 [NUM_ROWS],
	input  logic                 out_ready,
	output logic                 adv,
	output logic                 out_valid,
	output code_t                read_data,
	output logic                 irq_level,
	output code_t                held_code
);

	code_t scan_code;
	code_t last_key_q;
	logic  irq_pending_q;
	logic  take;

	// The highest row that produced a code wins.
	always_comb begin
		scan_code = '0;
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (lane_s1[i].hit) begin
				scan_code = lane_s1[i].code;
			end
		end
	end

	assign adv  = !out_valid || out_ready;
	assign take = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid     <= 1'b0;
			last_key_q    <= '0;
			irq_pending_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid <= valid_s1;
			end
			if (take) begin
				if (func_s1 == FUNC_READ) begin
					last_key_q    <= '0;
					irq_pending_q <= 1'b0;
				end else if (scan_code == '0 && last_key_q != '0) begin
					irq_pending_q <= 1'b1;
				end else begin
					last_key_q <= scan_code;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (func_s1 == FUNC_READ) begin
				read_data <= last_key_q;
				irq_level <= 1'b0;
				held_code <= '0;
			end else if (scan_code == '0 && last_key_q != '0) begin
				read_data <= '0;
				irq_level <= 1'b1;
				held_code <= last_key_q;
			end else begin
				read_data <= '0;
				irq_level <= irq_pending_q;
				held_code <= scan_code;
			end
		end
	end

endmodule

// ===== src/keyboard_matrix_ascii_encoder_top.sv =====
// Keyboard matrix to ASCII encoder.
// Input channel (in_valid/in_ready) carries one item per transfer: func selects a scan
// tick (key_rows, shift_down, ctrl_down) or a read of the keyboard data port.
// Output channel (out_valid/out_ready) returns exactly one result per item:
// read_data, the interrupt level irq_level and the held code held_code.
// Seven row lanes decode their rows in parallel into a stage register; the merge
// stage picks the highest row with a code and updates the held code and interrupt.
// The result passes the lane stage register and then the output register; throughput is
// one item per cycle while the receiver does not stall, with the merge stage updating
// its state as each item is taken.
// When the receiver stalls, the result holds in the output register and one more
// item waits in the lane stage before in_ready drops.
// Reset clears the stored last key, the pending interrupt and both pipeline valid flags.
module keyboard_matrix_ascii_encoder_top
	import kmae_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         func,
	input  logic [NUM_ROWS*ROW_BITS-1:0] key_rows,
	input  logic                         shift_down,
	input  logic                         ctrl_down,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CODE_BITS-1:0]         read_data,
	output logic                         irq_level,
	output logic [CODE_BITS-1:0]         held_code
);

	lane_res_t lane_res [NUM_ROWS];
	lane_res_t lane_s1  [NUM_ROWS];
	logic      func_s1;
	logic      valid_s1;
	logic      adv2;

	for (genvar g = 0; g < NUM_ROWS; g++) begin : g_lane
		kmae_lane u_lane (
			.row_idx    (row_idx_t'(g)),
			.row        (key_rows[g*ROW_BITS +: ROW_BITS]),
			.shift_down (shift_down),
			.ctrl_down  (ctrl_down),
			.res        (lane_res[g])
		);
	end

	assign in_ready = !valid_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			lane_s1 <= lane_res;
		end
	end

	kmae_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.func_s1   (func_s1),
		.lane_s1   (lane_s1),
		.out_ready (out_ready),
		.adv       (adv2),
		.out_valid (out_valid),
		.read_data (read_data),
		.irq_level (irq_level),
		.held_code (held_code)
	);

endmodule

// ===== src/kmae_checker.sv =====
module kmae_checker
	import kmae_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [CODE_BITS-1:0] read_data,
	input  logic                 irq_level,
	input  logic [CODE_BITS-1:0] held_code
);

	// A stalled result keeps its payload until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(irq_level) && $stable(held_code))
		else $error("result changed while stalled");

	// The interrupt is only up while a code is held.
	a_irq_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_level |-> held_code != '0)
		else $error("interrupt without held code");

	// A read that returns a code leaves nothing held and the interrupt cleared.
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_data != '0 |-> held_code == '0 && !irq_level)
		else $error("read did not clear state");

endmodule

bind keyboard_matrix_ascii_encoder_top kmae_checker u_kmae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.irq_level (irq_level),
	.held_code (held_code)
);
